### sv/salsa_core_16bit_keystream_assert.svh
// assertion macros for the salsa-style keystream core
// no dependencies; included by the top level only
`ifndef SALSA_CORE_16BIT_KEYSTREAM_ASSERT_SVH
`define SALSA_CORE_16BIT_KEYSTREAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SCK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SCK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/sck_pkg.sv
// types, constants and helper functions for the salsa-style keystream core
// no dependencies; imported by every module of the core
package sck_pkg;

    localparam int WORD_W     = 16;
    localparam int ROT_W      = 5;
    localparam int NUM_WORDS  = 16;
    localparam int KEY_WORDS  = 8;
    localparam int WORD_IDX_W = 4;
    localparam int KEY_IDX_W  = 3;
    localparam int STEP_W     = 2;
    localparam int NUM_LANES  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SCK_ROUND_COUNT = 20;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ROT_W-1:0]  t_rot;

    localparam logic [KEY_IDX_W-1:0]  KEY_LAST  = KEY_IDX_W'(KEY_WORDS - 1);
    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(NUM_WORDS - 1);
    localparam logic [STEP_W-1:0]     STEP_LAST = '1;

    // diagonal constants at positions 0, 5, 10, 15
    localparam t_word SIGMA [4] = '{16'h4554, 16'h4332, 16'h3032, 16'h3520};
    localparam t_rot  ROT_RESET [4] = '{5'd2, 5'd7, 5'd9, 5'd13};
    localparam t_word NONCE_RESET [4] = '{16'heaee, 16'h83a0, 16'hd9a6, 16'hb8f7};

    // quarter-round word groups: four columns, then four rows
    localparam logic [WORD_IDX_W-1:0] QR_IDX [8][4] = '{
        '{4'd0,  4'd4,  4'd8,  4'd12},
        '{4'd5,  4'd9,  4'd13, 4'd1},
        '{4'd10, 4'd14, 4'd2,  4'd6},
        '{4'd15, 4'd3,  4'd7,  4'd11},
        '{4'd0,  4'd1,  4'd2,  4'd3},
        '{4'd5,  4'd6,  4'd7,  4'd4},
        '{4'd10, 4'd11, 4'd8,  4'd9},
        '{4'd15, 4'd12, 4'd13, 4'd14}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_FIRST,
        CFG_ROT_SECOND,
        CFG_ROT_THIRD,
        CFG_ROT_FOURTH,
        CFG_NONCE0,
        CFG_NONCE1,
        CFG_NONCE2,
        CFG_NONCE3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic                  key_we;
        logic [KEY_IDX_W-1:0]  key_idx;
        logic                  load;
        logic                  round_en;
        logic [STEP_W-1:0]     step;
        logic                  row_pass;
        logic                  out_en;
        logic [WORD_IDX_W-1:0] out_idx;
        logic                  out_last;
    } t_dp_cmd;

    // left rotate; zero and anything from sixteen up leave the word as is
    function automatic t_word rotl16(input t_word v, input t_rot amt);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} << amt[ROT_W-2:0];
        if (amt[ROT_W-1]) begin
            return v;
        end
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

### sv/salsa_core_16bit_keystream.sv
// key items: one per cycle while o_busy is low; the eighth starts a block
// block: a load step, column and row passes of update steps, then sixteen output words; o_busy high throughout
// after the eighth item: ST_LOAD, the round passes, ST_OUT, then the output register holds the first word
// a new block's key items are taken only once o_busy falls; the four-lane update step sets the round time
// synchronous active-low reset: rotations and nonce to defaults, key count zero
// results come one per cycle on o_valid; the receiver cannot stall them
`include "salsa_core_16bit_keystream_assert.svh"

module salsa_core_16bit_keystream
    import sck_pkg::*;
#(
    parameter int ROUND_COUNT = SCK_ROUND_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // key item channel
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [WORD_W-1:0]     i_key_word,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // keystream items, one cycle each
    output logic                  o_valid,
    output logic [WORD_W-1:0]     o_keystream_word,
    output logic                  o_last_word
);

    // command bundle from sequencer to datapath
    t_dp_cmd w_cmd;

    // sequencer: counts keys, steps column and row passes, walks output words
    sck_ctrl #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd)
    );

    // datapath: 16-word state, four add-rotate-xor lanes, output adder
    sck_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_key_word       (i_key_word),
        .i_cmd            (w_cmd),
        .o_valid          (o_valid),
        .o_keystream_word (o_keystream_word),
        .o_last_word      (o_last_word)
    );

    // last flag only rides on a valid word
    `SCK_ASSERT_IMP(a_last_has_valid, i_clk, i_rst_n, o_last_word, o_valid, "last without valid")
    // the sixteen words of a block come back to back
    `SCK_ASSERT_NXT(a_words_contiguous, i_clk, i_rst_n, o_valid && !o_last_word, o_valid, "gap in block")
    // every word but the last is shown while the block is still busy
    `SCK_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid && !o_last_word, o_busy, "word while idle")
    // a block only starts from an accepted key item
    `SCK_ASSERT_IMP(a_busy_from_start, i_clk, i_rst_n, $rose(o_busy), $past(i_start), "busy without item")

endmodule

### sv/sck_ctrl.sv
// sequencer for the keystream core: key collection, rounds and output words
// depends on sck_pkg; drives sck_dp through a t_dp_cmd struct
module sck_ctrl
    import sck_pkg::*;
#(
    parameter int ROUND_COUNT = SCK_ROUND_COUNT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    localparam int DOUBLES = (ROUND_COUNT + 1) / 2;
    localparam int DBL_W   = $clog2(DOUBLES + 1);
    localparam logic [DBL_W-1:0] DBL_LAST = DBL_W'(DOUBLES - 1);

    t_state                r_state, n_state;
    logic [KEY_IDX_W-1:0]  r_key_cnt, n_key_cnt;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_row, n_row;
    logic [DBL_W-1:0]      r_dbl, n_dbl;
    logic [WORD_IDX_W-1:0] r_out_idx, n_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_key_cnt <= '0;
            r_step    <= '0;
            r_row     <= 1'b0;
            r_dbl     <= '0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_key_cnt <= n_key_cnt;
            r_step    <= n_step;
            r_row     <= n_row;
            r_dbl     <= n_dbl;
            r_out_idx <= n_out_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_key_cnt = r_key_cnt;
        n_step    = r_step;
        n_row     = r_row;
        n_dbl     = r_dbl;
        n_out_idx = r_out_idx;

        o_cmd          = '0;
        o_cmd.key_idx  = r_key_cnt;
        o_cmd.step     = r_step;
        o_cmd.row_pass = r_row;
        o_cmd.out_idx  = r_out_idx;
        o_cmd.out_last = (r_out_idx == WORD_LAST);

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.key_we = 1'b1;
                    n_key_cnt    = r_key_cnt + KEY_IDX_W'(1);
                    if (r_key_cnt == KEY_LAST) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_row      = 1'b0;
                n_dbl      = '0;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_row = ~r_row;
                    if (r_row) begin
                        if (r_dbl == DBL_LAST) begin
                            n_state   = ST_OUT;
                            n_out_idx = '0;
                        end else begin
                            n_dbl = r_dbl + DBL_W'(1);
                        end
                    end
                end
            end
            ST_OUT: begin
                o_cmd.out_en = 1'b1;
                n_out_idx    = r_out_idx + WORD_IDX_W'(1);
                if (r_out_idx == WORD_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### sv/sck_dp.sv
// datapath of the keystream core: config, key store, four quarter-round lanes
// depends on sck_pkg; commanded by sck_ctrl
module sck_dp
    import sck_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_word                 i_key_word,
    input  t_dp_cmd               i_cmd,
    output logic                  o_valid,
    output t_word                 o_keystream_word,
    output logic                  o_last_word
);

    t_rot  r_rot   [4];
    t_word r_nonce [4];
    t_word r_key   [KEY_WORDS];
    t_word r_work  [NUM_WORDS];
    t_word n_work  [NUM_WORDS];
    t_word w_start [NUM_WORDS];

    logic [WORD_IDX_W-1:0] w_src0 [NUM_LANES];
    logic [WORD_IDX_W-1:0] w_src1 [NUM_LANES];
    logic [WORD_IDX_W-1:0] w_tgt  [NUM_LANES];
    t_word                 w_sum  [NUM_LANES];

    t_word r_out_word;
    logic  r_out_valid;
    logic  r_out_last;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_rot[i]   <= ROT_RESET[i];
                r_nonce[i] <= NONCE_RESET[i];
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_FIRST:  r_rot[0]   <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_SECOND: r_rot[1]   <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_THIRD:  r_rot[2]   <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_FOURTH: r_rot[3]   <= i_cfg_data[ROT_W-1:0];
                CFG_NONCE0:     r_nonce[0] <= i_cfg_data[WORD_W-1:0];
                CFG_NONCE1:     r_nonce[1] <= i_cfg_data[WORD_W-1:0];
                CFG_NONCE2:     r_nonce[2] <= i_cfg_data[WORD_W-1:0];
                CFG_NONCE3:     r_nonce[3] <= i_cfg_data[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            r_key[i_cmd.key_idx] <= i_key_word;
        end
    end

    // starting layout
    always_comb begin
        w_start[0]  = SIGMA[0];
        w_start[5]  = SIGMA[1];
        w_start[10] = SIGMA[2];
        w_start[15] = SIGMA[3];
        for (int i = 0; i < 4; i++) begin
            w_start[1 + i]  = r_key[i];
            w_start[6 + i]  = r_nonce[i];
            w_start[11 + i] = r_key[4 + i];
        end
    end

    // one update step of all four quarter-rounds of a pass
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_src0[l] = QR_IDX[{i_cmd.row_pass, 2'(l)}][i_cmd.step];
            w_src1[l] = QR_IDX[{i_cmd.row_pass, 2'(l)}][i_cmd.step + STEP_W'(3)];
            w_tgt[l]  = QR_IDX[{i_cmd.row_pass, 2'(l)}][i_cmd.step + STEP_W'(1)];
            w_sum[l]  = r_work[w_src0[l]] + r_work[w_src1[l]];
        end
    end

    always_comb begin
        n_work = r_work;
        if (i_cmd.load) begin
            n_work = w_start;
        end else if (i_cmd.round_en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                n_work[w_tgt[l]] = r_work[w_tgt[l]] ^ rotl16(w_sum[l], r_rot[i_cmd.step]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    // feed-forward add into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_out_word <= r_work[i_cmd.out_idx] + w_start[i_cmd.out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.out_en;
            r_out_last  <= i_cmd.out_en & i_cmd.out_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_keystream_word = r_out_word;
    assign o_last_word      = r_out_last;

endmodule
